@@ src/tpg_pkg.sv @@
// Shared constants and types for the ternary packed matrix-vector block.
package tpg_pkg;

   localparam int CODES_PER_BYTE = 4;
   localparam int CODE_WIDTH     = 2;
   localparam int BYTE_WIDTH     = 8;
   localparam int SUM_WIDTH      = 27;
   localparam int INDEX_WIDTH    = 10;
   localparam int DIM_WIDTH      = 11;

   localparam logic [DIM_WIDTH-1:0] DIM_RESET = 11'd1024;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   localparam logic [CODE_WIDTH-1:0] CODE_PLUS  = 2'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_MINUS = 2'd2;

   typedef logic signed [SUM_WIDTH-1:0] sum_type;

   // Weight byte on its way from the address stage to the accumulate stage.
   typedef struct packed {
      logic                         valid;
      logic                         row_done;
      logic                         final_row;
      logic [CODES_PER_BYTE-1:0]    lane_en;
      logic [BYTE_WIDTH-1:0]        weight;
      logic [INDEX_WIDTH-1:0]       row_index;
   } stage_type;

endpackage

@@ src/tpg_if.sv @@
// Channel interfaces: request, response and register write.
interface tpg_req_if import tpg_pkg::*; #(parameter int VALUE_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [VALUE_WIDTH-1:0] vec_value;
   logic [BYTE_WIDTH-1:0]         weight_byte;

   modport source (output valid, cmd, vec_value, weight_byte, input ready);
   modport sink   (input valid, cmd, vec_value, weight_byte, output ready);
endinterface

interface tpg_rsp_if import tpg_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [SUM_WIDTH-1:0] row_sum;
   logic [INDEX_WIDTH-1:0]      row_index;
   logic                        last;

   modport source (output valid, row_sum, row_index, last, input ready);
   modport sink   (input valid, row_sum, row_index, last, output ready);
endinterface

interface tpg_csr_if import tpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DIM_WIDTH-1:0] dim;

   modport source (output valid, dim, input ready);
   modport sink   (input valid, dim, output ready);
endinterface

@@ src/tpg_vec_mem.sv @@
// Vector store: one row holds four elements, lane write, registered row read.
module tpg_vec_mem import tpg_pkg::*; #(
   parameter int VALUE_WIDTH = 16,
   parameter int ROWS        = 256,
   parameter int RAW         = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [RAW-1:0]                              wr_row,
   input  logic [1:0]                                  wr_lane,
   input  logic [VALUE_WIDTH-1:0]                      wr_data,
   input  logic                                        rd_en,
   input  logic [RAW-1:0]                              rd_row,
   output logic [CODES_PER_BYTE-1:0][VALUE_WIDTH-1:0]  rd_data
);

   logic [CODES_PER_BYTE-1:0][VALUE_WIDTH-1:0] mem [ROWS];
   logic [CODES_PER_BYTE-1:0][VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane] <= wr_data;
      end
   end

   // Hold the last read while no weight beat comes in.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tpg_ctrl.sv @@
// Address stage: dimension register, load pointer, byte and row counters.
module tpg_ctrl import tpg_pkg::*; #(
   parameter int MAX_DIM     = 1024,
   parameter int VALUE_WIDTH = 16,
   parameter int RAW         = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   tpg_req_if.sink                req_ch,
   tpg_csr_if.sink                csr_ch,
   input  logic                   advance,
   output stage_type              stage,
   output logic                   wr_en,
   output logic [RAW-1:0]         wr_row,
   output logic [1:0]             wr_lane,
   output logic [VALUE_WIDTH-1:0] wr_data,
   output logic                   rd_en,
   output logic [RAW-1:0]         rd_row
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int NW = $clog2(MAX_DIM + 1);
   localparam int BW = RAW + 1;

   logic [DIM_WIDTH-1:0]      dim_ff, dim_in;
   logic [AW-1:0]             load_ptr_ff, load_ptr_in;
   logic [RAW-1:0]            byte_ff, byte_in;
   logic [AW-1:0]             row_ff, row_in;
   logic [NW-1:0]             dim_use;
   logic [BW-1:0]             bytes_per_row;
   logic [RAW-1:0]            byte_eff;
   logic                      row_done;
   logic                      final_row;
   logic                      load_wrap;
   logic [CODES_PER_BYTE-1:0] lane_en;
   logic                      load_fire;
   logic                      weight_fire;
   stage_type                 stage_ff, stage_in;

   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   assign load_fire   = req_ch.valid && advance && (req_ch.cmd == CMD_LOAD);
   assign weight_fire = req_ch.valid && advance && (req_ch.cmd == CMD_WEIGHT);

   always_comb begin
      // Clamp the dimension into 1..MAX_DIM.
      if (dim_ff == '0) begin
         dim_use = NW'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         dim_use = NW'(MAX_DIM);
      end else begin
         dim_use = NW'(dim_ff);
      end
      bytes_per_row = BW'((32'(dim_use) + CODES_PER_BYTE - 1) / CODES_PER_BYTE);
      if (32'(byte_ff) >= 32'(bytes_per_row)) begin
         byte_eff = RAW'(32'(bytes_per_row) - 1);
      end else begin
         byte_eff = byte_ff;
      end
      row_done  = (32'(byte_eff) + 1) >= 32'(bytes_per_row);
      final_row = (32'(row_ff) + 1) >= 32'(dim_use);
      load_wrap = (32'(load_ptr_ff) + 1) >= 32'(dim_use);
      for (int s = 0; s < CODES_PER_BYTE; s++) begin
         lane_en[s] = (32'(byte_eff) * CODES_PER_BYTE + s) < 32'(dim_use);
      end
   end

   always_comb begin
      dim_in      = dim_ff;
      load_ptr_in = load_ptr_ff;
      byte_in     = byte_ff;
      row_in      = row_ff;
      stage_in    = stage_ff;
      if (csr_ch.valid) begin
         dim_in = csr_ch.dim;
      end
      if (load_fire) begin
         load_ptr_in = load_wrap ? '0 : AW'(32'(load_ptr_ff) + 1);
      end
      if (weight_fire) begin
         if (row_done) begin
            byte_in = '0;
            row_in  = final_row ? '0 : AW'(32'(row_ff) + 1);
         end else begin
            byte_in = RAW'(32'(byte_eff) + 1);
         end
      end
      if (advance) begin
         stage_in.valid     = weight_fire;
         stage_in.row_done  = row_done;
         stage_in.final_row = final_row;
         stage_in.lane_en   = lane_en;
         stage_in.weight    = req_ch.weight_byte;
         stage_in.row_index = INDEX_WIDTH'(row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff         <= DIM_RESET;
         load_ptr_ff    <= '0;
         byte_ff        <= '0;
         row_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         dim_ff      <= dim_in;
         load_ptr_ff <= load_ptr_in;
         byte_ff     <= byte_in;
         row_ff      <= row_in;
         stage_ff    <= stage_in;
      end
   end

   assign stage   = stage_ff;
   assign wr_en   = load_fire;
   assign wr_row  = RAW'(load_ptr_ff >> 2);
   assign wr_lane = load_ptr_ff[1:0];
   assign wr_data = req_ch.vec_value;
   assign rd_en   = weight_fire;
   assign rd_row  = byte_eff;

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      weight_fire && row_done |=> byte_ff == '0)
      else $error("byte counter did not restart after a row's last byte");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid && !advance |=> $stable(stage_ff))
      else $error("stalled weight beat changed in the address stage");

endmodule

@@ src/tpg_acc.sv @@
// Accumulate stage: four add/subtract lanes, row accumulator, output register.
module tpg_acc import tpg_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  stage_type                                  stage,
   input  logic [CODES_PER_BYTE-1:0][VALUE_WIDTH-1:0] rd_data,
   output logic                                       advance,
   tpg_rsp_if.source                                  rsp_ch
);

   sum_type                lane_term [CODES_PER_BYTE];
   sum_type                total;
   sum_type                acc_ff, acc_in;
   sum_type                out_sum_ff, out_sum_in;
   logic [INDEX_WIDTH-1:0] out_index_ff, out_index_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   retire;
   logic                   emit;

   always_comb begin
      logic [CODE_WIDTH-1:0] code;
      sum_type               elem;
      code = '0;
      elem = '0;
      for (int s = 0; s < CODES_PER_BYTE; s++) begin
         code = stage.weight[CODE_WIDTH*s +: CODE_WIDTH];
         elem = sum_type'(signed'(rd_data[s]));
         if (!stage.lane_en[s]) begin
            lane_term[s] = '0;
         end else if (code == CODE_PLUS) begin
            lane_term[s] = elem;
         end else if (code == CODE_MINUS) begin
            lane_term[s] = -elem;
         end else begin
            lane_term[s] = '0;
         end
      end
      total = acc_ff;
      for (int s = 0; s < CODES_PER_BYTE; s++) begin
         total = total + lane_term[s];
      end
   end

   // Stall only when a finished row meets a full, untaken output register.
   assign advance = !stage.valid || !stage.row_done || !out_valid_ff || rsp_ch.ready;
   assign retire  = stage.valid && advance;
   assign emit    = retire && stage.row_done;

   always_comb begin
      acc_in       = acc_ff;
      out_sum_in   = out_sum_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (retire) begin
         acc_in = stage.row_done ? '0 : total;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_sum_in   = total;
         out_index_in = stage.row_index;
         out_last_in  = stage.final_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sum_ff   <= out_sum_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.row_sum   = out_sum_ff;
   assign rsp_ch.row_index = out_index_ff;
   assign rsp_ch.last      = out_last_ff;

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_ch.valid)
      else $error("finished row did not reach the output register");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> acc_ff == '0)
      else $error("accumulator not cleared after a row");

endmodule

@@ src/ternary_packed_gemv.sv @@
// Ternary-weight matrix-vector product over 2-bit packed weights, Q8.8 data.
//
// Channels: req_ch carries one beat per item. cmd = 0 writes vec_value into
// the vector store at the next load position (wrapping after dim-1); cmd = 1
// brings one weight byte of four 2-bit codes, lowest first (01 add, 10
// subtract, 00/11 skip). A row takes ceil(dim/4) bytes; its last byte yields
// one rsp_ch beat with row_sum, row_index and last (set on row dim-1).
// csr_ch writes dim; write it only while the block is idle.
// Timing: one request beat per cycle while req_ch.ready is high. The edge that
// accepts a row's last byte reads the store and registers the byte in the
// address stage; the accumulate stage then adds the four lanes into the output
// register once it can advance, and the sum shows as valid on rsp_ch.
// Reset: dim = 1024, counters and accumulator zero. The vector store is not
// cleared; load every element before weights use it. No clearing pass.
// Stall: while a result waits on rsp_ch, the block keeps taking beats until a
// second finished row meets the full output register; then req_ch.ready
// drops until the response is taken.
module ternary_packed_gemv import tpg_pkg::*; #(
   parameter int MAX_DIM     = 1024,
   parameter int VALUE_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tpg_req_if.sink    req_ch,
   tpg_rsp_if.source  rsp_ch,
   tpg_csr_if.sink    csr_ch
);

   localparam int ROWS = (MAX_DIM + CODES_PER_BYTE - 1) / CODES_PER_BYTE;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

   stage_type                                  stage;
   logic                                       advance;
   logic                                       wr_en;
   logic [RAW-1:0]                             wr_row;
   logic [1:0]                                 wr_lane;
   logic [VALUE_WIDTH-1:0]                     wr_data;
   logic                                       rd_en;
   logic [RAW-1:0]                             rd_row;
   logic [CODES_PER_BYTE-1:0][VALUE_WIDTH-1:0] rd_data;

   tpg_ctrl #(
      .MAX_DIM     (MAX_DIM),
      .VALUE_WIDTH (VALUE_WIDTH),
      .RAW         (RAW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .csr_ch  (csr_ch),
      .advance (advance),
      .stage   (stage),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_row  (rd_row)
   );

   tpg_vec_mem #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .ROWS        (ROWS),
      .RAW         (RAW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   tpg_acc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_acc (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .rd_data (rd_data),
      .advance (advance),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ bench/ternary_packed_gemv_tb.sv @@
// Self-checking testbench for ternary_packed_gemv: predicts each row sum and checks every beat.
module ternary_packed_gemv_tb import tpg_pkg::*; ();

   localparam int VEC_DEPTH   = 1024;
   localparam int VALUE_W     = 16;
   localparam int HOLD_CYCLES = 60;

   typedef logic signed [VALUE_W-1:0] elem_type;

   typedef struct {
      sum_type                row_sum;
      logic [INDEX_WIDTH-1:0] row_index;
      logic                   last;
   } row_sum_type;

   class gemv_row_checker;
      elem_type             vec_mem [VEC_DEPTH];
      bit                   loaded [VEC_DEPTH];
      int unsigned          load_ptr;
      int unsigned          byte_pos;
      int unsigned          row_cnt;
      longint               acc;
      logic [DIM_WIDTH-1:0] dim_reg;
      row_sum_type          rows_due[$];
      int                   mismatches;

      function new();
         load_ptr   = 0;
         byte_pos   = 0;
         row_cnt    = 0;
         acc        = 0;
         dim_reg    = DIM_RESET;
         mismatches = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function int unsigned dim_used();
         if (dim_reg == 0) return 1;
         if (dim_reg > VEC_DEPTH) return VEC_DEPTH;
         return dim_reg;
      endfunction

      function int unsigned row_bytes();
         return (dim_used() + CODES_PER_BYTE - 1) / CODES_PER_BYTE;
      endfunction

      // A byte position left past the row end by a smaller dim acts as the row's last byte.
      function int unsigned weight_pos();
         return (byte_pos >= row_bytes()) ? row_bytes() - 1 : byte_pos;
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      // Turn add/subtract codes that would hit never-loaded elements into skip codes.
      function logic [BYTE_WIDTH-1:0] mask_unloaded(logic [BYTE_WIDTH-1:0] raw);
         logic [BYTE_WIDTH-1:0] wb;
         logic [CODE_WIDTH-1:0] code;
         int unsigned           j;
         int                    s;
         wb = raw;
         for (s = 0; s < CODES_PER_BYTE; s++) begin
            j    = weight_pos() * CODES_PER_BYTE + s;
            code = wb[CODE_WIDTH*s +: CODE_WIDTH];
            if (j < dim_used() && !loaded[j] && (code == CODE_PLUS || code == CODE_MINUS))
               wb[CODE_WIDTH*s +: CODE_WIDTH] = {code[1], code[1]};
         end
         return wb;
      endfunction

      function void take_request(logic cmd, elem_type value, logic [BYTE_WIDTH-1:0] wb);
         int unsigned           n;
         int unsigned           b;
         int unsigned           j;
         int unsigned           p;
         int                    s;
         logic [CODE_WIDTH-1:0] code;
         row_sum_type           r;
         n = dim_used();
         if (cmd == CMD_LOAD) begin
            p          = load_ptr % VEC_DEPTH;
            vec_mem[p] = value;
            loaded[p]  = 1'b1;
            load_ptr   = (p + 1 >= n) ? 0 : p + 1;
            return;
         end
         b = weight_pos();
         for (s = 0; s < CODES_PER_BYTE; s++) begin
            j    = b * CODES_PER_BYTE + s;
            code = wb[CODE_WIDTH*s +: CODE_WIDTH];
            if (j < n) begin
               if (code == CODE_PLUS)
                  acc += vec_mem[j];
               else if (code == CODE_MINUS)
                  acc -= vec_mem[j];
            end
         end
         if (b + 1 < row_bytes()) begin
            byte_pos = b + 1;
            return;
         end
         r.row_sum   = sum_type'(acc);
         r.row_index = row_cnt[INDEX_WIDTH-1:0];
         r.last      = (row_cnt + 1 >= n);
         rows_due.push_back(r);
         row_cnt  = r.last ? 0 : row_cnt + 1;
         byte_pos = 0;
         acc      = 0;
      endfunction

      function void check_row(sum_type row_sum, logic [INDEX_WIDTH-1:0] row_index, logic last);
         row_sum_type e;
         if (rows_due.size() == 0) begin
            $error("unexpected row beat: row_sum %0d, row_index %0d, last %0b",
                   row_sum, row_index, last);
            mismatches++;
            return;
         end
         e = rows_due.pop_front();
         if (row_sum !== e.row_sum) begin
            $error("row_sum: expected %0d, got %0d", e.row_sum, row_sum);
            mismatches++;
         end
         if (row_index !== e.row_index) begin
            $error("row_index: expected %0d, got %0d", e.row_index, row_index);
            mismatches++;
         end
         if (last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   gap_pct = 0;
   bit   hold_req = 1'b0;

   gemv_row_checker rows;

   tpg_req_if #(.VALUE_WIDTH(VALUE_W)) req_ch ();
   tpg_rsp_if                          rsp_ch ();
   tpg_csr_if                          csr_ch ();

   ternary_packed_gemv #(.MAX_DIM(VEC_DEPTH), .VALUE_WIDTH(VALUE_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   function automatic elem_type pick_value();
      unique case ($urandom_range(0, 11))
         0: return elem_type'(16'h7FFF);
         1: return elem_type'(16'h8000);
         2: return elem_type'(16'hFFFF);
         3: return elem_type'(16'h0000);
         default: return elem_type'($urandom);
      endcase
   endfunction

   task automatic send_item(logic cmd, elem_type value, logic [BYTE_WIDTH-1:0] raw);
      logic [BYTE_WIDTH-1:0] wb;
      @(negedge clock);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      wb = (cmd == CMD_WEIGHT) ? rows.mask_unloaded(raw) : raw;
      req_ch.valid       = 1'b1;
      req_ch.cmd         = cmd;
      req_ch.vec_value   = value;
      req_ch.weight_byte = wb;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      rows.take_request(cmd, value, wb);
   endtask

   // Drain all rows, let the pipeline settle, then write dim.
   task automatic write_dim(logic [DIM_WIDTH-1:0] value);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (rows.pending() != 0) @(posedge clock);
      repeat (6) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.dim   = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      rows.dim_reg = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_phase(logic [DIM_WIDTH-1:0] dim_value, int loads, int items, int gaps,
                            bit hold);
      int unsigned n;
      logic        cmd;
      write_dim(dim_value);
      gap_pct = gaps;
      n = rows.dim_used();
      if (hold) hold_req = 1'b1;
      repeat ((loads < n) ? loads : n) send_item(CMD_LOAD, pick_value(), BYTE_WIDTH'($urandom));
      repeat (items) begin
         // stray loads land mid-row and move the load pointer
         cmd = ($urandom_range(0, 99) < 12) ? CMD_LOAD : CMD_WEIGHT;
         send_item(cmd, pick_value(), BYTE_WIDTH'($urandom));
      end
   endtask

   // Result side: random short stalls plus one long hold on request.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (hold_req) begin
            hold_req     = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_ch.ready = 1'b0;
         end else if ($urandom_range(0, 99) < gap_pct) begin
            stall_left   = $urandom_range(0, 3);
            rsp_ch.ready = 1'b0;
         end else
            rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         rows.check_row(rsp_ch.row_sum, rsp_ch.row_index, rsp_ch.last);
   end

   initial begin
      rows               = new();
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_LOAD;
      req_ch.vec_value   = '0;
      req_ch.weight_byte = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.dim         = DIM_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: dim 5, extremes, load wrap, every code, ignored tail codes, row wrap.
      write_dim(DIM_WIDTH'(5));
      gap_pct = 25;
      send_item(CMD_LOAD, elem_type'(16'h7FFF), BYTE_WIDTH'($urandom));
      send_item(CMD_LOAD, elem_type'(16'h8000), BYTE_WIDTH'($urandom));
      send_item(CMD_LOAD, elem_type'(16'hFFFF), BYTE_WIDTH'($urandom));
      send_item(CMD_LOAD, elem_type'(16'h0001), BYTE_WIDTH'($urandom));
      send_item(CMD_LOAD, elem_type'(16'h0100), BYTE_WIDTH'($urandom));
      send_item(CMD_LOAD, elem_type'(16'h0080), BYTE_WIDTH'($urandom));
      send_item(CMD_WEIGHT, pick_value(), 8'h55);
      send_item(CMD_WEIGHT, pick_value(), 8'hE5);
      send_item(CMD_WEIGHT, pick_value(), 8'hAA);
      send_item(CMD_WEIGHT, pick_value(), 8'h02);
      send_item(CMD_WEIGHT, pick_value(), 8'hE4);
      send_item(CMD_WEIGHT, pick_value(), 8'h00);
      send_item(CMD_WEIGHT, pick_value(), 8'hFF);
      send_item(CMD_LOAD, elem_type'(16'h7FFF), BYTE_WIDTH'($urandom));
      send_item(CMD_WEIGHT, pick_value(), 8'h01);
      send_item(CMD_WEIGHT, pick_value(), 8'h55);
      send_item(CMD_WEIGHT, pick_value(), 8'h55);
      send_item(CMD_WEIGHT, pick_value(), 8'h96);
      send_item(CMD_WEIGHT, pick_value(), 8'h01);

      run_phase(DIM_WIDTH'(1), 4, 80, 20, 1'b1);
      run_phase(DIM_WIDTH'(8), 64, 80, 30, 1'b0);
      run_phase(DIM_WIDTH'(17), 64, 80, 0, 1'b0);
      run_phase(DIM_WIDTH'(3), 64, 80, 30, 1'b0);
      run_phase(DIM_WIDTH'(31), 64, 80, 30, 1'b0);
      run_phase(DIM_WIDTH'(0), 64, 60, 30, 1'b0);
      run_phase(DIM_WIDTH'(13), 64, 80, 0, 1'b0);
      run_phase(DIM_WIDTH'(2), 64, 60, 30, 1'b0);
      run_phase(DIM_WIDTH'(16), 64, 80, 30, 1'b0);
      run_phase(DIM_WIDTH'(5), 64, 60, 30, 1'b0);
      run_phase(DIM_WIDTH'(1024), 128, 270, 30, 1'b0);
      run_phase(DIM_WIDTH'(2047), 32, 260, 0, 1'b0);
      run_phase(DIM_WIDTH'(6), 64, 60, 30, 1'b0);
      repeat (3) run_phase(DIM_WIDTH'($urandom_range(1, 40)), 64, 60, 30, 1'b0);
      run_phase(DIM_WIDTH'($urandom_range(4, 24)), 64, 120, 0, 1'b0);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (rows.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (rows.mismatches == 0 && rows.pending() == 0)
         $display("ternary_packed_gemv_tb: PASS");
      else
         $display("ternary_packed_gemv_tb: FAIL");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("ternary_packed_gemv_tb: FAIL");
      $finish;
   end

endmodule
